/* src/fsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fsp_pkg;

  // Default widths for the top-level parameters.
  localparam int SAMPLE_WIDTH_DEF = 20;
  localparam int COUNT_WIDTH_DEF  = 20;

  // APB data width and address width (seven registers at 4-byte spacing).
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 5;
  localparam int REG_IDX_WIDTH  = 3;

  // Register indexes.
  localparam logic [REG_IDX_WIDTH-1:0] REG_IDLE_RATE     = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_LAUNCH_ACCEL  = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_BURNOUT_ACCEL = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_LEVEL_PITCH   = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_STILL_RATE    = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_GLIDE_DWELL   = 3'd5;
  localparam logic [REG_IDX_WIDTH-1:0] REG_LANDED_DWELL  = 3'd6;

  // Threshold slots in the packed threshold bus.
  localparam int NUM_THRESH     = 5;
  localparam int TH_IDLE_RATE   = 0;
  localparam int TH_LAUNCH      = 1;
  localparam int TH_BURNOUT     = 2;
  localparam int TH_LEVEL_PITCH = 3;
  localparam int TH_STILL_RATE  = 4;

  // Reset values, 32 bits wide; truncated to the configured width.
  localparam logic [31:0] RST_IDLE_RATE     = 32'(1024);
  localparam logic [31:0] RST_LAUNCH_ACCEL  = 32'(-15360);
  localparam logic [31:0] RST_BURNOUT_ACCEL = 32'(-5120);
  localparam logic [31:0] RST_LEVEL_PITCH   = 32'(5120);
  localparam logic [31:0] RST_STILL_RATE    = 32'(51);
  localparam logic [31:0] RST_GLIDE_DWELL   = 32'(100);
  localparam logic [31:0] RST_LANDED_DWELL  = 32'(100000);

  // Phase codes as seen on the result port.
  localparam logic [2:0] PHASE_STANDBY    = 3'd0;
  localparam logic [2:0] PHASE_CALIBRATE  = 3'd1;
  localparam logic [2:0] PHASE_BOOST      = 3'd2;
  localparam logic [2:0] PHASE_TRANSITION = 3'd3;
  localparam logic [2:0] PHASE_GLIDE      = 3'd4;
  localparam logic [2:0] PHASE_LANDED     = 3'd5;

  // Selector codes.
  localparam logic       ROLL_IGNORE    = 1'b0;
  localparam logic       ROLL_HOLD_ZERO = 1'b1;
  localparam logic [1:0] PITCH_IGNORE   = 2'd0;
  localparam logic [1:0] PITCH_LAUNCH   = 2'd1;
  localparam logic [1:0] PITCH_GLIDE    = 2'd2;
  localparam logic [1:0] GAIN_ZERO      = 2'd0;
  localparam logic [1:0] GAIN_BOOST     = 2'd1;
  localparam logic [1:0] GAIN_GLIDE     = 2'd2;

endpackage
`default_nettype wire

/* src/fsp_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module fsp_cfg
  import fsp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [APB_ADDR_WIDTH-1:0]             paddr,
  input  wire logic [APB_DATA_WIDTH-1:0]             pwdata,
  output logic      [APB_DATA_WIDTH-1:0]             prdata,
  output logic      [NUM_THRESH-1:0][SAMPLE_WIDTH-1:0] thresh,
  output logic      [COUNT_WIDTH-1:0]                glide_dwell,
  output logic      [COUNT_WIDTH-1:0]                landed_dwell
);

  logic                     wr_en;
  logic [REG_IDX_WIDTH-1:0] idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = paddr[APB_ADDR_WIDTH-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh[TH_IDLE_RATE]   <= RST_IDLE_RATE[SAMPLE_WIDTH-1:0];
      thresh[TH_LAUNCH]      <= RST_LAUNCH_ACCEL[SAMPLE_WIDTH-1:0];
      thresh[TH_BURNOUT]     <= RST_BURNOUT_ACCEL[SAMPLE_WIDTH-1:0];
      thresh[TH_LEVEL_PITCH] <= RST_LEVEL_PITCH[SAMPLE_WIDTH-1:0];
      thresh[TH_STILL_RATE]  <= RST_STILL_RATE[SAMPLE_WIDTH-1:0];
      glide_dwell            <= RST_GLIDE_DWELL[COUNT_WIDTH-1:0];
      landed_dwell           <= RST_LANDED_DWELL[COUNT_WIDTH-1:0];
    end else if (wr_en) begin
      case (idx)
        REG_IDLE_RATE:     thresh[TH_IDLE_RATE]   <= pwdata[SAMPLE_WIDTH-1:0];
        REG_LAUNCH_ACCEL:  thresh[TH_LAUNCH]      <= pwdata[SAMPLE_WIDTH-1:0];
        REG_BURNOUT_ACCEL: thresh[TH_BURNOUT]     <= pwdata[SAMPLE_WIDTH-1:0];
        REG_LEVEL_PITCH:   thresh[TH_LEVEL_PITCH] <= pwdata[SAMPLE_WIDTH-1:0];
        REG_STILL_RATE:    thresh[TH_STILL_RATE]  <= pwdata[SAMPLE_WIDTH-1:0];
        REG_GLIDE_DWELL:   glide_dwell            <= pwdata[COUNT_WIDTH-1:0];
        REG_LANDED_DWELL:  landed_dwell           <= pwdata[COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Thresholds read back sign-extended, dwells zero-extended.
  always_comb begin
    case (idx)
      REG_IDLE_RATE:     prdata = APB_DATA_WIDTH'(signed'(thresh[TH_IDLE_RATE]));
      REG_LAUNCH_ACCEL:  prdata = APB_DATA_WIDTH'(signed'(thresh[TH_LAUNCH]));
      REG_BURNOUT_ACCEL: prdata = APB_DATA_WIDTH'(signed'(thresh[TH_BURNOUT]));
      REG_LEVEL_PITCH:   prdata = APB_DATA_WIDTH'(signed'(thresh[TH_LEVEL_PITCH]));
      REG_STILL_RATE:    prdata = APB_DATA_WIDTH'(signed'(thresh[TH_STILL_RATE]));
      REG_GLIDE_DWELL:   prdata = APB_DATA_WIDTH'(glide_dwell);
      REG_LANDED_DWELL:  prdata = APB_DATA_WIDTH'(landed_dwell);
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* src/fsp_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
module fsp_seq
  import fsp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    step,
  input  wire logic        [NUM_THRESH-1:0][SAMPLE_WIDTH-1:0] thresh,
  input  wire logic        [COUNT_WIDTH-1:0]           glide_dwell,
  input  wire logic        [COUNT_WIDTH-1:0]           landed_dwell,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          roll_rate,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          pitch_rate,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          yaw_rate,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          accel_forward,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          yaw_angle,
  input  wire logic signed [SAMPLE_WIDTH-1:0]          pitch_angle,
  output logic             [2:0]                       phase_next,
  output logic                                         roll_next,
  output logic             [1:0]                       pitch_sel_next,
  output logic             [1:0]                       gain_next,
  output logic signed      [SAMPLE_WIDTH-1:0]          heading_next,
  output logic signed      [SAMPLE_WIDTH-1:0]          pitch_latch_next
);

  typedef enum logic [2:0] {
    ST_STANDBY    = PHASE_STANDBY,
    ST_CALIBRATE  = PHASE_CALIBRATE,
    ST_BOOST      = PHASE_BOOST,
    ST_TRANSITION = PHASE_TRANSITION,
    ST_GLIDE      = PHASE_GLIDE,
    ST_LANDED     = PHASE_LANDED
  } state_t;

  state_t                         state, state_next;
  logic        [COUNT_WIDTH-1:0]  dwell, dwell_next, dwell_bump;
  logic signed [SAMPLE_WIDTH-1:0] heading_latch, pitch_latch;
  logic signed [SAMPLE_WIDTH-1:0] th_idle, th_launch, th_burnout, th_level, th_still;

  assign th_idle    = signed'(thresh[TH_IDLE_RATE]);
  assign th_launch  = signed'(thresh[TH_LAUNCH]);
  assign th_burnout = signed'(thresh[TH_BURNOUT]);
  assign th_level   = signed'(thresh[TH_LEVEL_PITCH]);
  assign th_still   = signed'(thresh[TH_STILL_RATE]);

  // Saturating increment.
  assign dwell_bump = (&dwell) ? dwell : dwell + 1'b1;

  always_comb begin
    state_next       = state;
    dwell_next       = dwell;
    heading_next     = heading_latch;
    pitch_latch_next = pitch_latch;
    case (state)
      ST_STANDBY: begin
        if (roll_rate < th_idle && yaw_rate < th_idle) begin
          state_next = ST_CALIBRATE;
          dwell_next = '0;
        end
      end
      ST_CALIBRATE: begin
        if (accel_forward < th_launch) begin
          state_next = ST_BOOST;
        end else begin
          heading_next     = yaw_angle;
          pitch_latch_next = pitch_angle;
        end
      end
      ST_BOOST: begin
        if (accel_forward > th_burnout) begin
          state_next = ST_TRANSITION;
          dwell_next = '0;
        end
      end
      ST_TRANSITION: begin
        if (pitch_angle < th_level) begin
          dwell_next = dwell_bump;
          if (dwell_bump >= glide_dwell) begin
            state_next = ST_GLIDE;
            dwell_next = '0;
          end
        end
      end
      ST_GLIDE: begin
        if (roll_rate < th_still && pitch_rate < th_still) begin
          dwell_next = dwell_bump;
          if (dwell_bump >= landed_dwell) begin
            state_next = ST_LANDED;
            dwell_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_next = state_next;
    case (state_next)
      ST_BOOST: begin
        roll_next      = ROLL_HOLD_ZERO;
        pitch_sel_next = PITCH_LAUNCH;
        gain_next      = GAIN_BOOST;
      end
      ST_TRANSITION: begin
        roll_next      = ROLL_HOLD_ZERO;
        pitch_sel_next = PITCH_LAUNCH;
        gain_next      = GAIN_ZERO;
      end
      ST_GLIDE: begin
        roll_next      = ROLL_HOLD_ZERO;
        pitch_sel_next = PITCH_GLIDE;
        gain_next      = GAIN_GLIDE;
      end
      default: begin
        roll_next      = ROLL_IGNORE;
        pitch_sel_next = PITCH_IGNORE;
        gain_next      = GAIN_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_STANDBY;
      dwell         <= '0;
      heading_latch <= '0;
      pitch_latch   <= '0;
    end else if (step) begin
      state         <= state_next;
      dwell         <= dwell_next;
      heading_latch <= heading_next;
      pitch_latch   <= pitch_latch_next;
    end
  end

endmodule
`default_nettype wire

/* src/flight_phase_sequencer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Flight phase sequencer core.
// Sample channel: one attitude-filter sample per beat (rates, forward accel,
//   yaw and pitch, signed Q10). Beat taken when sample_valid && !sample_stall.
// Result channel: one result beat per sample: new phase, roll/pitch/gain
//   selector codes and the yaw/pitch latched during calibrate.
//   Beat taken when result_valid && !result_stall.
// Config: APB-style, 7 registers at byte offsets 0x00..0x18, pready tied
//   high; write only while no samples are in flight.
// Path: a sample beat is taken into the input register, and result_valid
//   rises once it moves on into the result register. Throughput: one
//   sample per cycle while the result channel is not stalled; the phase/dwell
//   state update sits between the two registers.
// Stall: a stalled result holds; the input register still takes one more
//   sample, and sample_stall rises only when both stages are full.
// Reset (rst, synchronous): phase standby, dwell and latches zero, threshold
//   registers to their defaults, both stages empty.
module flight_phase_sequencer_core
  import fsp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // APB
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [APB_ADDR_WIDTH-1:0]      paddr,
  input  wire logic [APB_DATA_WIDTH-1:0]      pwdata,
  output logic      [APB_DATA_WIDTH-1:0]      prdata,
  output logic                                pready,
  // sample channel
  input  wire logic                           sample_valid,
  output logic                                sample_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] roll_rate,
  input  wire logic signed [SAMPLE_WIDTH-1:0] pitch_rate,
  input  wire logic signed [SAMPLE_WIDTH-1:0] yaw_rate,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_forward,
  input  wire logic signed [SAMPLE_WIDTH-1:0] yaw_angle,
  input  wire logic signed [SAMPLE_WIDTH-1:0] pitch_angle,
  // result channel
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic             [2:0]              phase,
  output logic                                roll_select,
  output logic             [1:0]              pitch_select,
  output logic             [1:0]              gain_select,
  output logic signed      [SAMPLE_WIDTH-1:0] start_heading,
  output logic signed      [SAMPLE_WIDTH-1:0] start_pitch
);

  logic [NUM_THRESH-1:0][SAMPLE_WIDTH-1:0] thresh;
  logic [COUNT_WIDTH-1:0]                  glide_dwell, landed_dwell;

  // input register
  logic                           s1_valid;
  logic signed [SAMPLE_WIDTH-1:0] s1_roll, s1_pitch_rate, s1_yaw_rate;
  logic signed [SAMPLE_WIDTH-1:0] s1_accel, s1_yaw_angle, s1_pitch_angle;

  // sequencer next results
  logic        [2:0]              phase_nx;
  logic                           roll_nx;
  logic        [1:0]              pitch_nx, gain_nx;
  logic signed [SAMPLE_WIDTH-1:0] heading_nx, pitch_latch_nx;

  logic take_in, advance;

  assign pready = 1'b1;

  // s1 moves to the result register whenever that register is free or drains
  assign advance      = s1_valid & (~result_valid | ~result_stall);
  assign sample_stall = s1_valid & ~advance;
  assign take_in      = sample_valid & ~sample_stall;

  fsp_cfg #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .thresh      (thresh),
    .glide_dwell (glide_dwell),
    .landed_dwell(landed_dwell)
  );

  fsp_seq #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .thresh          (thresh),
    .glide_dwell     (glide_dwell),
    .landed_dwell    (landed_dwell),
    .roll_rate       (s1_roll),
    .pitch_rate      (s1_pitch_rate),
    .yaw_rate        (s1_yaw_rate),
    .accel_forward   (s1_accel),
    .yaw_angle       (s1_yaw_angle),
    .pitch_angle     (s1_pitch_angle),
    .phase_next      (phase_nx),
    .roll_next       (roll_nx),
    .pitch_sel_next  (pitch_nx),
    .gain_next       (gain_nx),
    .heading_next    (heading_nx),
    .pitch_latch_next(pitch_latch_nx)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= take_in | (s1_valid & ~advance);
      result_valid <= advance | (result_valid & result_stall);
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_roll        <= roll_rate;
      s1_pitch_rate  <= pitch_rate;
      s1_yaw_rate    <= yaw_rate;
      s1_accel       <= accel_forward;
      s1_yaw_angle   <= yaw_angle;
      s1_pitch_angle <= pitch_angle;
    end
    if (advance) begin
      phase         <= phase_nx;
      roll_select   <= roll_nx;
      pitch_select  <= pitch_nx;
      gain_select   <= gain_nx;
      start_heading <= heading_nx;
      start_pitch   <= pitch_latch_nx;
    end
  end

endmodule
`default_nettype wire

/* src/fsp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module fsp_checker
  import fsp_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    result_valid,
  input wire logic                    result_stall,
  input wire logic [2:0]              phase,
  input wire logic                    roll_select,
  input wire logic [1:0]              pitch_select,
  input wire logic [1:0]              gain_select,
  input wire logic [SAMPLE_WIDTH-1:0] start_heading
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(phase)
      && $stable(start_heading))
    else $error("stalled result beat changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result beat right after reset");

  // glide selectors
  a_glide_sel: assert property (@(posedge clk) disable iff (rst)
    result_valid && phase == PHASE_GLIDE |->
      roll_select == ROLL_HOLD_ZERO && pitch_select == PITCH_GLIDE
      && gain_select == GAIN_GLIDE)
    else $error("glide selectors wrong");

  // outside flight phases all selectors idle
  a_idle_sel: assert property (@(posedge clk) disable iff (rst)
    result_valid && (phase == PHASE_STANDBY || phase == PHASE_CALIBRATE
      || phase == PHASE_LANDED) |->
      roll_select == ROLL_IGNORE && pitch_select == PITCH_IGNORE
      && gain_select == GAIN_ZERO)
    else $error("selectors active outside flight");

  // landed is terminal
  a_landed: assert property (@(posedge clk) disable iff (rst)
    result_valid && phase == PHASE_LANDED |=> !result_valid || phase == PHASE_LANDED)
    else $error("left landed phase");

endmodule

bind flight_phase_sequencer_core fsp_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_fsp_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .phase        (phase),
  .roll_select  (roll_select),
  .pitch_select (pitch_select),
  .gain_select  (gain_select),
  .start_heading(start_heading)
);
`default_nettype wire
